[rtl/lfra_pkg.sv]
// Package for the letter frequency running average block: sizes, codes,
// payload structs and the controller state type. No dependencies.
package lfra_pkg;

    localparam int SYMBOLS     = 256;
    localparam int COUNT_BITS  = 32;
    localparam int FRAC_BITS   = 24;
    localparam int WEIGHT_BITS = 40;

    localparam int SYM_W   = $clog2(SYMBOLS);
    localparam int FREQ_W  = FRAC_BITS + 1;
    localparam int D_W     = WEIGHT_BITS + 1;
    localparam int NUM_W   = D_W + FREQ_W;
    localparam int W_LO_W  = WEIGHT_BITS / 2;
    localparam int W_HI_W  = WEIGHT_BITS - W_LO_W;
    localparam int PROD_W  = FREQ_W + W_HI_W;
    localparam int DCNT_W  = $clog2(FREQ_W);

    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};
    localparam logic [FREQ_W-1:0]      ONE_FIX    = FREQ_W'(1) << FRAC_BITS;

    localparam logic [OP_W-1:0] OP_TEXT  = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_D = 3'd3;

    localparam logic [BYTE_W-1:0] SKIP_A_RST = 8'd32;
    localparam logic [BYTE_W-1:0] SKIP_B_RST = 8'd10;
    localparam logic [BYTE_W-1:0] SKIP_C_RST = 8'd13;
    localparam logic [BYTE_W-1:0] SKIP_D_RST = 8'd9;

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] data_byte;
    } lfra_in_t;

    typedef struct packed {
        logic                   status;
        logic [FREQ_W-1:0]      frequency;
        logic [WEIGHT_BITS-1:0] total_weight;
    } lfra_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_M_CHECK,
        ST_M_RD,
        ST_M_MUL0,
        ST_M_MUL1,
        ST_M_SUM,
        ST_M_DIV,
        ST_DONE
    } lfra_state_t;

endpackage

[rtl/letter_frequency_running_average.sv]
// Top level of the letter frequency running average block.
// Depends on lfra_pkg, lfra_ram and lfra_div.
//
// Input items carry an opcode and a byte. A text byte (opcode 0) is counted
// in a per-symbol histogram unless it is NUL or matches a non-zero separator
// register; a to z count as A to Z. Text bytes are taken one per cycle while
// no read or merge is in progress, the count memory being updated by read,
// increment and write-back with forwarding between neighboring bytes. A read
// (opcode 2) returns one stored frequency; no further item is accepted until
// its result has passed from the READ state to the output register. An end
// of text (opcode 1) merges the histogram into the frequency table, one bin
// at a time through a read, the multiply steps, a sum and the
// one-bit-per-cycle divider, and no item is accepted meanwhile. An empty
// text answers with status 1. Results go to an output register; while the
// receiver stalls, text bytes are still accepted, and a read or merge
// waits with its result until the register is free. After reset a clearing
// pass over every address zeroes both memories before the first item is
// taken; configuration writes are taken at any time.
module letter_frequency_running_average (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lfra_pkg::lfra_in_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lfra_pkg::lfra_out_t            m_data,
    input  logic                           cfg_we,
    input  logic [lfra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfra_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lfra_pkg::*;

    lfra_state_t            state_reg, state_next;
    logic [SYM_W-1:0]       j_reg, j_next;
    logic [COUNT_BITS-1:0]  text_total_reg, text_total_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [SYM_W-1:0]       s1_addr_reg, s1_addr_next;
    logic                   lw_valid_reg, lw_valid_next;
    logic [SYM_W-1:0]       lw_addr_reg, lw_addr_next;
    logic [COUNT_BITS-1:0]  lw_data_reg, lw_data_next;
    logic                   m_valid_reg, m_valid_next;
    lfra_out_t              m_data_reg, m_data_next;
    logic [BYTE_W-1:0]      skip_reg [4];
    logic                   status_reg, status_next;
    logic                   rd_oor_reg, rd_oor_next;
    logic [D_W-1:0]         d_reg, d_next;
    logic [FREQ_W-1:0]      f_reg, f_next;
    logic [COUNT_BITS-1:0]  c_reg, c_next;
    logic [PROD_W-1:0]      p0_reg, p0_next;
    logic [PROD_W-1:0]      p1_reg, p1_next;

    logic                   accept;
    logic                   out_free;
    logic [BYTE_W-1:0]      byte_up;
    logic                   drop;
    logic                   count_en;
    logic                   rd_oor;
    logic [COUNT_BITS-1:0]  cnt_cur;
    logic [COUNT_BITS-1:0]  cnt_inc;

    logic                   cnt_we, cnt_re;
    logic [SYM_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0]  cnt_wdata, cnt_rdata;
    logic                   freq_we, freq_re;
    logic [SYM_W-1:0]       freq_waddr, freq_raddr;
    logic [FREQ_W-1:0]      freq_wdata, freq_rdata;

    logic                   div_start, div_done;
    logic [NUM_W-1:0]       div_num;
    logic [FREQ_W-1:0]      div_quot;

    lfra_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_cnt_ram (
        .clk   (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    lfra_ram #(.WIDTH(FREQ_W), .DEPTH(SYMBOLS)) u_freq_ram (
        .clk   (aclk),
        .we    (freq_we),
        .waddr (freq_waddr),
        .wdata (freq_wdata),
        .re    (freq_re),
        .raddr (freq_raddr),
        .rdata (freq_rdata)
    );

    lfra_div u_div (
        .clk   (aclk),
        .rstn  (aresetn),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        drop = (s_data.data_byte == '0);
        for (int k = 0; k < 4; k++) begin
            if (skip_reg[k] != '0 && skip_reg[k] == s_data.data_byte) begin
                drop = 1'b1;
            end
        end
        if (s_data.data_byte >= CHAR_LOWER_A && s_data.data_byte <= CHAR_LOWER_Z) begin
            byte_up = s_data.data_byte - CASE_OFFSET;
        end else begin
            byte_up = s_data.data_byte;
        end
    end

    assign count_en = !drop && ({1'b0, byte_up} < (BYTE_W + 1)'(SYMBOLS));
    assign rd_oor   = ({1'b0, s_data.data_byte} >= (BYTE_W + 1)'(SYMBOLS));

    assign cnt_cur = (lw_valid_reg && lw_addr_reg == s1_addr_reg) ? lw_data_reg : cnt_rdata;
    assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

    assign div_num = NUM_W'(p0_reg) + (NUM_W'(p1_reg) << W_LO_W)
                   + (NUM_W'(c_reg) << FRAC_BITS);

    always_comb begin
        state_next      = state_reg;
        j_next          = j_reg;
        text_total_next = text_total_reg;
        weight_next     = weight_reg;
        s1_valid_next   = 1'b0;
        s1_addr_next    = s1_addr_reg;
        lw_valid_next   = s1_valid_reg;
        lw_addr_next    = s1_addr_reg;
        lw_data_next    = cnt_inc;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_data_next     = m_data_reg;
        status_next     = status_reg;
        rd_oor_next     = rd_oor_reg;
        d_next          = d_reg;
        f_next          = f_reg;
        c_next          = c_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        div_start       = 1'b0;

        cnt_we     = s1_valid_reg;
        cnt_waddr  = s1_addr_reg;
        cnt_wdata  = cnt_inc;
        cnt_re     = 1'b0;
        cnt_raddr  = byte_up[SYM_W-1:0];
        freq_we    = 1'b0;
        freq_waddr = j_reg;
        freq_wdata = '0;
        freq_re    = 1'b0;
        freq_raddr = s_data.data_byte[SYM_W-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we     = 1'b1;
                cnt_waddr  = j_reg;
                cnt_wdata  = '0;
                freq_we    = 1'b1;
                if (j_reg == SYM_W'(SYMBOLS - 1)) begin
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    j_next = j_reg + SYM_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.opcode)
                        OP_TEXT: begin
                            if (count_en) begin
                                cnt_re        = 1'b1;
                                s1_valid_next = 1'b1;
                                s1_addr_next  = byte_up[SYM_W-1:0];
                                if (text_total_reg != COUNT_MAX) begin
                                    text_total_next = text_total_reg + COUNT_BITS'(1);
                                end
                            end
                        end
                        OP_MERGE: begin
                            state_next = ST_M_CHECK;
                        end
                        OP_READ: begin
                            freq_re     = 1'b1;
                            rd_oor_next = rd_oor;
                            state_next  = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = 1'b0;
                    m_data_next.frequency     = rd_oor_reg ? '0 : freq_rdata;
                    m_data_next.total_weight  = weight_reg;
                    state_next                = ST_IDLE;
                end
            end
            ST_M_CHECK: begin
                if (text_total_reg == '0) begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    status_next = 1'b0;
                    d_next      = D_W'(weight_reg) + D_W'(text_total_reg);
                    state_next  = ST_M_RD;
                end
            end
            ST_M_RD: begin
                cnt_re     = 1'b1;
                cnt_raddr  = j_reg;
                freq_re    = 1'b1;
                freq_raddr = j_reg;
                state_next = ST_M_MUL0;
            end
            ST_M_MUL0: begin
                f_next     = freq_rdata;
                c_next     = cnt_rdata;
                p0_next    = PROD_W'(freq_rdata) * PROD_W'(weight_reg[W_LO_W-1:0]);
                state_next = ST_M_MUL1;
            end
            ST_M_MUL1: begin
                p1_next    = PROD_W'(f_reg) * PROD_W'(weight_reg[WEIGHT_BITS-1:W_LO_W]);
                state_next = ST_M_SUM;
            end
            ST_M_SUM: begin
                div_start  = 1'b1;
                state_next = ST_M_DIV;
            end
            ST_M_DIV: begin
                if (div_done) begin
                    freq_we    = 1'b1;
                    freq_wdata = (div_quot > ONE_FIX) ? ONE_FIX : div_quot;
                    cnt_we     = 1'b1;
                    cnt_waddr  = j_reg;
                    cnt_wdata  = '0;
                    if (j_reg == SYM_W'(SYMBOLS - 1)) begin
                        j_next          = '0;
                        weight_next     = d_reg[D_W-1] ? WEIGHT_MAX
                                                       : d_reg[WEIGHT_BITS-1:0];
                        text_total_next = '0;
                        state_next      = ST_DONE;
                    end else begin
                        j_next     = j_reg + SYM_W'(1);
                        state_next = ST_M_RD;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = status_reg;
                    m_data_next.frequency     = '0;
                    m_data_next.total_weight  = weight_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            j_reg          <= '0;
            text_total_reg <= '0;
            weight_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            skip_reg[0]    <= SKIP_A_RST;
            skip_reg[1]    <= SKIP_B_RST;
            skip_reg[2]    <= SKIP_C_RST;
            skip_reg[3]    <= SKIP_D_RST;
        end else begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            text_total_reg <= text_total_next;
            weight_reg     <= weight_next;
            s1_valid_reg   <= s1_valid_next;
            lw_valid_reg   <= lw_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SKIP_A: skip_reg[0] <= cfg_wdata;
                    CFG_SKIP_B: skip_reg[1] <= cfg_wdata;
                    CFG_SKIP_C: skip_reg[2] <= cfg_wdata;
                    CFG_SKIP_D: skip_reg[3] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg <= s1_addr_next;
        lw_addr_reg <= lw_addr_next;
        lw_data_reg <= lw_data_next;
        m_data_reg  <= m_data_next;
        status_reg  <= status_next;
        rd_oor_reg  <= rd_oor_next;
        d_reg       <= d_next;
        f_reg       <= f_next;
        c_reg       <= c_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_READ || state_reg == ST_DONE))
        else $error("result appeared outside a read or merge completion");

    a_count_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(accept && s_data.opcode == OP_TEXT))
        else $error("count update without an accepted text item");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (state_reg != ST_M_DIV && state_reg != ST_CLEAR))
        else $error("count update collides with a merge or clear write");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_DIV && div_done) |-> div_quot <= ONE_FIX)
        else $error("merged frequency above one");

    a_merge_clears_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !status_reg) |-> text_total_reg == '0)
        else $error("text total not cleared after merge");

endmodule

[rtl/lfra_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module lfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lfra_div.sv]
// Restoring divider, one quotient bit per cycle, for the frequency merge.
// Depends on lfra_pkg.
module lfra_div (
    input  logic                       clk,
    input  logic                       rstn,
    input  logic                       start,
    input  logic [lfra_pkg::NUM_W-1:0]  num,
    input  logic [lfra_pkg::D_W-1:0]    den,
    output logic                       done,
    output logic [lfra_pkg::FREQ_W-1:0] quot
);
    import lfra_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    den_reg, den_next;
    logic [FREQ_W-1:0] qn_reg, qn_next;
    logic [D_W:0]      trial;
    logic              qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qn_next   = qn_reg;
        trial     = {rem_reg, qn_reg[FREQ_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(FREQ_W - 1);
            rem_next  = num[NUM_W-1 -: D_W];
            qn_next   = num[FREQ_W-1:0];
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = qbit ? D_W'(trial - {1'b0, den_reg}) : trial[D_W-1:0];
            qn_next  = {qn_reg[FREQ_W-2:0], qbit};
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        qn_reg  <= qn_next;
    end

    assign done = done_reg;
    assign quot = qn_reg;

endmodule
